// ===== src/s128_pkg.sv =====
package s128_pkg;

  localparam int WORD_W         = 64;
  localparam int MAX_ROUND_KEYS = 72;
  localparam int RK_AW          = $clog2(MAX_ROUND_KEYS);
  localparam int STEP_W         = $clog2(MAX_ROUND_KEYS / 2);
  localparam int CFG_IDX_W      = 3;
  localparam int MODE_W         = 2;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [RK_AW-1:0]     rk_addr_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [MODE_W-1:0]    key_mode_t;

  // configuration register indexes
  localparam cfg_idx_t REG_KEY_WORD0      = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_KEY_WORD1      = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_KEY_WORD2      = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_KEY_WORD3      = CFG_IDX_W'(3);
  localparam cfg_idx_t REG_KEY_LENGTH_MODE = CFG_IDX_W'(4);

  localparam key_mode_t MODE_128 = MODE_W'(0);
  localparam key_mode_t MODE_192 = MODE_W'(1);

  localparam logic REQ_ENCRYPT = 1'b0;
  localparam logic REQ_DECRYPT = 1'b1;

  localparam word_t CONST_C  = 64'hffff_ffff_ffff_fffc;
  localparam word_t SEQ_Z128 = 64'h7369_f885_192c_0ef5;
  localparam word_t SEQ_Z192 = 64'hfc2c_e512_07a6_35db;
  localparam word_t SEQ_Z256 = 64'hfdc9_4c3a_046d_678b;

  localparam rk_addr_t KEYS_128 = RK_AW'(68);
  localparam rk_addr_t KEYS_192 = RK_AW'(69);
  localparam rk_addr_t KEYS_256 = RK_AW'(MAX_ROUND_KEYS);

  function automatic word_t rotl(word_t v, int n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic word_t rotr(word_t v, int n);
    return (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic word_t mix(word_t v);
    return (rotl(v, 1) & rotl(v, 8)) ^ rotl(v, 2);
  endfunction

endpackage

// ===== src/s128_if.sv =====
interface s128_in_if;
  import s128_pkg::*;
  logic  valid;
  logic  ready;
  logic  req_type;
  word_t block_word0;
  word_t block_word1;
  modport source (output valid, req_type, block_word0, block_word1, input ready);
  modport sink   (input valid, req_type, block_word0, block_word1, output ready);
endinterface

interface s128_out_if;
  import s128_pkg::*;
  logic  valid;
  logic  ready;
  word_t out_word0;
  word_t out_word1;
  modport source (output valid, out_word0, out_word1, input ready);
  modport sink   (input valid, out_word0, out_word1, output ready);
endinterface

interface s128_cfg_if;
  import s128_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/simon_128_block_cipher.sv =====
// SIMON 128-bit block cipher with 128, 192 or 256-bit key, ECB, one block per beat.
// cfg: register writes (index 0..3 key words, 4 key-length mode), always ready.
//   A write to a valid index marks the round keys stale; other indexes are ignored.
// req: one beat carries req_type (0 encrypt, 1 decrypt) and the x/y block words.
//   req.ready is high only while no block is in flight.
// rsp: one beat per request with the two result words, held until taken.
// Sequence: the first block after reset or a key write first expands the round
//   keys into a 72-entry store, one key per cycle (68, 69 or 72 keys).
// Each block then passes through a fetch state, one cycle per round step
//   (34, 35 or 36 for 128, 192, 256-bit keys) and a done state that loads the
//   output register. req.ready returns once the result is loaded, so a new block
//   is taken only after the previous one has left the core. The shared double-round
//   unit and the two-port round-key store serve every round step.
// The output register parts the two sides: a new request is taken while the
//   previous result waits; a finished block holds in the core until the
//   output register is free.
// Reset (rst, synchronous) clears the key registers and mode to zero, drops any
//   block in flight and any pending result, and marks the round keys stale.
module simon_128_block_cipher (
  input  logic clk,
  input  logic rst,
  s128_cfg_if.sink   cfg,
  s128_in_if.sink    req,
  s128_out_if.source rsp
);
  import s128_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXPAND = 3'd1;
  localparam logic [2:0] ST_FETCH  = 3'd2;
  localparam logic [2:0] ST_RUN    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam rk_addr_t SEQ_LEN = RK_AW'(WORD_W);

  logic [2:0] state;

  word_t     key_word0, key_word1, key_word2, key_word3;
  key_mode_t key_length_mode;
  logic      keys_ready;

  word_t    rk_mem [MAX_ROUND_KEYS];
  rk_addr_t exp_idx;
  word_t    win1, win2, win3, win4;

  rk_addr_t addr_a, addr_b;
  word_t    ka, kb;
  logic     rd_en;

  logic  decrypt;
  word_t x, y, x_next, y_next;
  step_t step;

  word_t res_word0, res_word1;
  logic  res_valid;
  logic  res_load;

  // mode decode
  logic     mode128, mode192, mode256;
  rk_addr_t key_count, init_words;
  step_t    last_step;

  assign mode128 = (key_length_mode == MODE_128);
  assign mode192 = (key_length_mode == MODE_192);
  assign mode256 = !mode128 && !mode192;

  always_comb begin
    case (key_length_mode)
      MODE_128: begin
        key_count  = KEYS_128;
        init_words = RK_AW'(2);
        last_step  = STEP_W'(33);
      end
      MODE_192: begin
        key_count  = KEYS_192;
        init_words = RK_AW'(3);
        last_step  = STEP_W'(34);
      end
      default: begin
        key_count  = KEYS_256;
        init_words = RK_AW'(4);
        last_step  = STEP_W'(35);
      end
    endcase
  end

  // key expansion word
  rk_addr_t exp_j, special_j, init_sel;
  word_t    z_seq, back_word, extra_word, init_word, exp_calc, exp_word;
  logic     z_bit;

  assign exp_j     = exp_idx - init_words;
  assign special_j = mode128 ? RK_AW'(64) : RK_AW'(65);
  assign init_sel  = init_words - exp_idx - RK_AW'(1);

  always_comb begin
    case (key_length_mode)
      MODE_128: z_seq = SEQ_Z128;
      MODE_192: z_seq = SEQ_Z192;
      default:  z_seq = SEQ_Z256;
    endcase
    case (init_sel[1:0])
      2'd0:    init_word = key_word0;
      2'd1:    init_word = key_word1;
      2'd2:    init_word = key_word2;
      default: init_word = key_word3;
    endcase
  end

  // past the end of the z sequence, one extra round constant bit is set
  assign z_bit      = (exp_j < SEQ_LEN) ? z_seq[exp_j[5:0]] : (exp_j == special_j);
  assign back_word  = mode128 ? win2 : (mode192 ? win3 : win4);
  assign extra_word = mode256 ? (win3 ^ rotr(win3, 1)) : '0;
  assign exp_calc   = CONST_C ^ word_t'(z_bit) ^ back_word ^ rotr(win1, 3)
                      ^ rotr(win1, 4) ^ extra_word;
  assign exp_word   = (exp_idx < init_words) ? init_word : exp_calc;

  // round datapath: one double round, or the single round of the 192-bit key
  logic  single_step;
  word_t first_in, first_out, second_out;

  assign single_step = mode192 && (decrypt ? (step == '0) : (step == last_step));
  assign first_in    = decrypt ? y : x;
  assign first_out   = (decrypt ? x : y) ^ mix(first_in) ^ ka;
  assign second_out  = first_in ^ mix(first_out) ^ kb;

  always_comb begin
    if (single_step) begin
      // single round then word swap (undone first when decrypting)
      if (decrypt) begin
        x_next = y;
        y_next = first_out;
      end else begin
        x_next = first_out;
        y_next = x;
      end
    end else if (decrypt) begin
      x_next = first_out;
      y_next = second_out;
    end else begin
      x_next = second_out;
      y_next = first_out;
    end
  end

  // round-key store: one write port, two registered read ports
  assign addr_b = decrypt ? (addr_a - RK_AW'(1)) : (addr_a + RK_AW'(1));
  assign rd_en  = (state == ST_FETCH) || ((state == ST_RUN) && (step != last_step));

  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) begin
      rk_mem[exp_idx] <= exp_word;
    end
    if (rd_en) begin
      ka <= rk_mem[addr_a];
      kb <= rk_mem[addr_b];
    end
  end

  assign cfg.ready     = 1'b1;
  assign req.ready     = (state == ST_IDLE);
  assign rsp.valid     = res_valid;
  assign rsp.out_word0 = res_word0;
  assign rsp.out_word1 = res_word1;

  // load the output register once it is empty or being taken
  assign res_load = (state == ST_DONE) && (!res_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      keys_ready      <= 1'b0;
      res_valid       <= 1'b0;
      key_word0       <= '0;
      key_word1       <= '0;
      key_word2       <= '0;
      key_word3       <= '0;
      key_length_mode <= MODE_128;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_KEY_WORD0: begin
            key_word0  <= cfg.data;
            keys_ready <= 1'b0;
          end
          REG_KEY_WORD1: begin
            key_word1  <= cfg.data;
            keys_ready <= 1'b0;
          end
          REG_KEY_WORD2: begin
            key_word2  <= cfg.data;
            keys_ready <= 1'b0;
          end
          REG_KEY_WORD3: begin
            key_word3  <= cfg.data;
            keys_ready <= 1'b0;
          end
          REG_KEY_LENGTH_MODE: begin
            key_length_mode <= cfg.data[MODE_W-1:0];
            keys_ready      <= 1'b0;
          end
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready && !res_load) begin
        res_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            decrypt <= req.req_type;
            x       <= req.block_word0;
            y       <= req.block_word1;
            addr_a  <= (req.req_type == REQ_DECRYPT) ? (key_count - RK_AW'(1)) : '0;
            step    <= '0;
            exp_idx <= '0;
            state   <= keys_ready ? ST_FETCH : ST_EXPAND;
          end
        end
        ST_EXPAND: begin
          win4    <= win3;
          win3    <= win2;
          win2    <= win1;
          win1    <= exp_word;
          exp_idx <= exp_idx + RK_AW'(1);
          if (exp_idx == key_count - RK_AW'(1)) begin
            keys_ready <= 1'b1;
            state      <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          // the 192-bit decrypt starts with the single round on the top key
          if (decrypt) begin
            addr_a <= mode192 ? (addr_a - RK_AW'(1)) : (addr_a - RK_AW'(2));
          end else begin
            addr_a <= addr_a + RK_AW'(2);
          end
          state <= ST_RUN;
        end
        ST_RUN: begin
          x <= x_next;
          y <= y_next;
          if (step == last_step) begin
            state <= ST_DONE;
          end else begin
            step   <= step + STEP_W'(1);
            addr_a <= decrypt ? (addr_a - RK_AW'(2)) : (addr_a + RK_AW'(2));
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (res_load) begin
            res_word0 <= x;
            res_word1 <= y;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/s128_chk.sv =====
module s128_chk (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input s128_pkg::word_t out_word0,
  input s128_pkg::word_t out_word1
);
  import s128_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(out_word0) && $stable(out_word1)))
    else $error("result words changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while a block is in flight");

  a_result_from_core: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no block in flight");

endmodule

bind simon_128_block_cipher s128_chk u_s128_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .out_word0 (rsp.out_word0),
  .out_word1 (rsp.out_word1)
);
